@@ design/mbx_pkg.sv @@
// ----------------------------------------------------------------------------
// mbx_pkg
// Shared constants for the multichannel mailbox FIFO: field widths, access
// codes, status bit positions and parameter defaults.
// ----------------------------------------------------------------------------
package mbx_pkg;

  // Field widths
  localparam int ACT_W     = 3;
  localparam int CHAN_W    = 4;
  localparam int WORD_W    = 32;
  localparam int RX_IRQ_W  = 8;

  // Channels addressable by the channel field
  localparam int MAX_CHANNELS = 16;

  // Parameter defaults
  localparam int FIFO_WORDS_DEF  = 64;
  localparam int TX_CHANNELS_DEF = 8;
  localparam int RX_CHANNELS_DEF = 8;

  // Access codes
  localparam logic [ACT_W-1:0] ACT_HOST_READ    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_HOST_WRITE   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_STATUS_READ  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_STATUS_WRITE = 3'd3;
  localparam logic [ACT_W-1:0] ACT_REMOTE_POP   = 3'd4;
  localparam logic [ACT_W-1:0] ACT_REMOTE_PUSH  = 3'd5;

  // Status bit positions
  localparam int ST_EMPTY_BIT    = 0;
  localparam int ST_OVERFLOW_BIT = 2;
  localparam int ST_FLUSH_BIT    = 4;

endpackage

@@ design/mbx_ctx_mem.sv @@
// ----------------------------------------------------------------------------
// mbx_ctx_mem
// Per-channel context store: one write port, one registered read port.
// Entries never written since reset read back as zero.
// ----------------------------------------------------------------------------
module mbx_ctx_mem #(
  parameter int DEPTH  = mbx_pkg::MAX_CHANNELS,
  parameter int DATA_W = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  valid_r;
  logic [DATA_W-1:0] rd_data_r;
  logic              rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  // Unwritten entries hold their reset value of zero
  assign rd_data = rd_valid_r ? rd_data_r : '0;

endmodule

@@ design/mbx_data_mem.sv @@
// ----------------------------------------------------------------------------
// mbx_data_mem
// Word storage for all channel FIFOs: one write port, one registered read.
// ----------------------------------------------------------------------------
module mbx_data_mem #(
  parameter int DEPTH = mbx_pkg::MAX_CHANNELS * mbx_pkg::FIFO_WORDS_DEF
) (
  input  logic                        clk,
  input  logic                        rd_en,
  input  logic [$clog2(DEPTH)-1:0]    rd_addr,
  output logic [mbx_pkg::WORD_W-1:0]  rd_data,
  input  logic                        wr_en,
  input  logic [$clog2(DEPTH)-1:0]    wr_addr,
  input  logic [mbx_pkg::WORD_W-1:0]  wr_data
);

  logic [mbx_pkg::WORD_W-1:0] mem [DEPTH];
  logic [mbx_pkg::WORD_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ design/multichannel_mailbox_fifo_unit.sv @@
// ----------------------------------------------------------------------------
// multichannel_mailbox_fifo_unit
// Sixteen-channel mailbox of 32-bit word FIFOs with host and remote access.
// ----------------------------------------------------------------------------
// Each input transaction is one access to one channel: host pop or push, status
// read or write, remote pop or push. Every access returns exactly one result
// transaction carrying the popped word or the status, an error flag for a pop
// from an empty FIFO, and the receive interrupt vector after the access. The
// block works on one access at a time. Each access first reads the channel
// context memory; a pop that returns data then reads the word memory, and
// the result goes to the output register once that register is free. A
// new access is taken as soon as the previous result has been loaded into
// the output register, even while that result is still stalled downstream.
module multichannel_mailbox_fifo_unit #(
  parameter int FIFO_WORDS  = mbx_pkg::FIFO_WORDS_DEF,
  parameter int TX_CHANNELS = mbx_pkg::TX_CHANNELS_DEF,
  parameter int RX_CHANNELS = mbx_pkg::RX_CHANNELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // Access transactions
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [mbx_pkg::ACT_W-1:0]    in_action,
  input  logic [mbx_pkg::CHAN_W-1:0]   in_channel,
  input  logic [mbx_pkg::WORD_W-1:0]   in_write_word,
  // Result transactions
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [mbx_pkg::WORD_W-1:0]   out_read_word,
  output logic                         out_access_error,
  output logic [mbx_pkg::RX_IRQ_W-1:0] out_rx_interrupts
);

  localparam int NCH      = mbx_pkg::MAX_CHANNELS;
  localparam int CH_SUM   = TX_CHANNELS + RX_CHANNELS;
  localparam int CH_TOTAL = (CH_SUM > NCH) ? NCH : CH_SUM;
  localparam int PTR_W    = $clog2(FIFO_WORDS);
  localparam int CNT_W    = $clog2(FIFO_WORDS + 1);
  localparam int CTX_W    = 2 * PTR_W + CNT_W + 1;
  localparam int DEPTH    = NCH * FIFO_WORDS;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int CHX_W    = mbx_pkg::CHAN_W + 1;

  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(FIFO_WORDS - 1);
  localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(FIFO_WORDS);
  localparam logic [ADDR_W-1:0] ROW_SZ   = ADDR_W'(FIFO_WORDS);

  // Control sequence, one hot
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,  // wait for an access
    ST_CTX  = 4'b0010,  // channel context available: act on it
    ST_DATA = 4'b0100,  // popped word available
    ST_OUT  = 4'b1000   // hand the result to the output register
  } state_t;

  state_t                       state_r, state_nxt;
  logic [mbx_pkg::ACT_W-1:0]    act_r, act_nxt;
  logic [mbx_pkg::CHAN_W-1:0]   chan_r, chan_nxt;
  logic [mbx_pkg::WORD_W-1:0]   word_r, word_nxt;
  logic [mbx_pkg::WORD_W-1:0]   res_data_r, res_data_nxt;
  logic                         res_err_r, res_err_nxt;
  logic [NCH-1:0]               nonempty_r, nonempty_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [mbx_pkg::WORD_W-1:0]   out_read_word_r, out_read_word_nxt;
  logic                         out_access_error_r, out_access_error_nxt;
  logic [mbx_pkg::RX_IRQ_W-1:0] out_rx_interrupts_r, out_rx_interrupts_nxt;

  // Memory ports
  logic                         ctx_rd_en;
  logic [CTX_W-1:0]             ctx_rd_data;
  logic                         ctx_wr_en;
  logic [CTX_W-1:0]             ctx_wr_data;
  logic                         dm_rd_en;
  logic [ADDR_W-1:0]            dm_rd_addr;
  logic [mbx_pkg::WORD_W-1:0]   dm_rd_data;
  logic                         dm_wr_en;
  logic [ADDR_W-1:0]            dm_wr_addr;

  // Context fields, as read and as written back
  logic [PTR_W-1:0] rp, wp, rp_new, wp_new;
  logic [CNT_W-1:0] cnt, cnt_new;
  logic             ovf, ovf_new;
  logic             exists, is_tx, pop_req, push_req, empty, full;
  logic [ADDR_W-1:0] row_base;
  logic [mbx_pkg::RX_IRQ_W-1:0] rx_mask;
  logic             in_accept, out_free;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;

  assign {ovf, cnt, wp, rp} = ctx_rd_data;
  assign ctx_wr_data        = {ovf_new, cnt_new, wp_new, rp_new};

  assign exists   = ({1'b0, chan_r} < CHX_W'(CH_TOTAL));
  assign is_tx    = ({1'b0, chan_r} < CHX_W'(TX_CHANNELS));
  assign pop_req  = exists && (((act_r == mbx_pkg::ACT_HOST_READ) && !is_tx) ||
                               ((act_r == mbx_pkg::ACT_REMOTE_POP) && is_tx));
  assign push_req = exists && (((act_r == mbx_pkg::ACT_HOST_WRITE) && is_tx) ||
                               ((act_r == mbx_pkg::ACT_REMOTE_PUSH) && !is_tx));
  assign empty    = (cnt == '0);
  assign full     = (cnt == CNT_FULL);
  assign row_base = ADDR_W'(chan_r) * ROW_SZ;

  assign dm_rd_addr = row_base + ADDR_W'(rp);
  assign dm_wr_addr = row_base + ADDR_W'(wp);

  // Receive interrupts: one bit per existing receive channel, first eight only
  for (genvar i = 0; i < mbx_pkg::RX_IRQ_W; i++) begin : g_rx_irq
    if ((i < RX_CHANNELS) && (TX_CHANNELS + i < CH_TOTAL)) begin : g_on
      assign rx_mask[i] = nonempty_r[TX_CHANNELS + i];
    end else begin : g_off
      assign rx_mask[i] = 1'b0;
    end
  end

  always_comb begin
    state_nxt             = state_r;
    act_nxt               = act_r;
    chan_nxt              = chan_r;
    word_nxt              = word_r;
    res_data_nxt          = res_data_r;
    res_err_nxt           = res_err_r;
    nonempty_nxt          = nonempty_r;
    out_valid_nxt         = out_valid_r && out_stall;
    out_read_word_nxt     = out_read_word_r;
    out_access_error_nxt  = out_access_error_r;
    out_rx_interrupts_nxt = out_rx_interrupts_r;
    ctx_rd_en             = 1'b0;
    ctx_wr_en             = 1'b0;
    dm_rd_en              = 1'b0;
    dm_wr_en              = 1'b0;
    rp_new                = rp;
    wp_new                = wp;
    cnt_new               = cnt;
    ovf_new               = ovf;

    case (state_r)
      ST_IDLE: begin
        // Latch the access and fetch its channel context
        if (in_accept) begin
          act_nxt   = in_action;
          chan_nxt  = in_channel;
          word_nxt  = in_write_word;
          ctx_rd_en = 1'b1;
          state_nxt = ST_CTX;
        end
      end

      ST_CTX: begin
        res_data_nxt = '0;
        res_err_nxt  = 1'b0;
        state_nxt    = ST_OUT;
        if (pop_req) begin
          if (empty) begin
            res_err_nxt = 1'b1;
          end else begin
            // Fetch the head word, advance the read side
            dm_rd_en  = 1'b1;
            rp_new    = (rp == PTR_LAST) ? '0 : rp + 1'b1;
            cnt_new   = cnt - 1'b1;
            state_nxt = ST_DATA;
          end
        end else if (push_req) begin
          if (full) begin
            // Drop the word and flag it
            ovf_new = 1'b1;
          end else begin
            dm_wr_en = 1'b1;
            wp_new   = (wp == PTR_LAST) ? '0 : wp + 1'b1;
            cnt_new  = cnt + 1'b1;
          end
        end else if (exists && (act_r == mbx_pkg::ACT_STATUS_READ)) begin
          res_data_nxt[mbx_pkg::ST_EMPTY_BIT]    = empty;
          res_data_nxt[mbx_pkg::ST_OVERFLOW_BIT] = ovf;
        end else if (exists && (act_r == mbx_pkg::ACT_STATUS_WRITE)) begin
          if (word_r[mbx_pkg::ST_OVERFLOW_BIT]) begin
            ovf_new = 1'b0;
          end
          if (word_r[mbx_pkg::ST_FLUSH_BIT]) begin
            rp_new  = '0;
            wp_new  = '0;
            cnt_new = '0;
          end
        end
        if (exists) begin
          ctx_wr_en            = 1'b1;
          nonempty_nxt[chan_r] = (cnt_new != '0);
        end
      end

      ST_DATA: begin
        res_data_nxt = dm_rd_data;
        state_nxt    = ST_OUT;
      end

      ST_OUT: begin
        // Hold until the output register is free, then load it
        if (out_free) begin
          out_valid_nxt         = 1'b1;
          out_read_word_nxt     = res_data_r;
          out_access_error_nxt  = res_err_r;
          out_rx_interrupts_nxt = rx_mask;
          state_nxt             = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      nonempty_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      nonempty_r  <= nonempty_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r               <= act_nxt;
    chan_r              <= chan_nxt;
    word_r              <= word_nxt;
    res_data_r          <= res_data_nxt;
    res_err_r           <= res_err_nxt;
    out_read_word_r     <= out_read_word_nxt;
    out_access_error_r  <= out_access_error_nxt;
    out_rx_interrupts_r <= out_rx_interrupts_nxt;
  end

  mbx_ctx_mem #(
    .DEPTH  (NCH),
    .DATA_W (CTX_W)
  ) u_ctx_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (ctx_rd_en),
    .rd_addr (in_channel),
    .rd_data (ctx_rd_data),
    .wr_en   (ctx_wr_en),
    .wr_addr (chan_r),
    .wr_data (ctx_wr_data)
  );

  mbx_data_mem #(
    .DEPTH (DEPTH)
  ) u_data_mem (
    .clk     (clk),
    .rd_en   (dm_rd_en),
    .rd_addr (dm_rd_addr),
    .rd_data (dm_rd_data),
    .wr_en   (dm_wr_en),
    .wr_addr (dm_wr_addr),
    .wr_data (word_r)
  );

  assign out_valid         = out_valid_r;
  assign out_read_word     = out_read_word_r;
  assign out_access_error  = out_access_error_r;
  assign out_rx_interrupts = out_rx_interrupts_r;

endmodule
